FILE: rtl/rdmd_pkg.sv
`default_nettype none
package rdmd_pkg;

  localparam int unsigned STEP_W     = 8;
  localparam int unsigned PWM_W      = 10;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [STEP_W-1:0] RAMP_STEP_RST      = STEP_W'(5);
  localparam logic [PWM_W-1:0]  PWM_LIMIT_RST      = PWM_W'(1023);
  localparam logic [DIST_W-1:0] OBSTACLE_LIMIT_RST = DIST_W'(80);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_STEP      = 2'd0,
    REG_PWM_LIMIT      = 2'd1,
    REG_OBSTACLE_LIMIT = 2'd2
  } reg_idx_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 2'd0,
    CMD_RAMP  = 2'd1,
    CMD_BEGIN = 2'd2,
    CMD_END   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_OFF = 2'd0,
    DIR_FWD = 2'd1,
    DIR_REV = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    LOP_HOLD = 2'd0,
    LOP_SET  = 2'd1,
    LOP_RAMP = 2'd2,
    LOP_ZERO = 2'd3
  } lane_op_e;

  typedef struct packed {
    lane_op_e op;
    logic     emit;
  } lane_ctrl_t;

  typedef struct packed {
    logic safety_active;
    logic obstacle_event;
  } flags_t;

endpackage
`default_nettype wire

FILE: rtl/rdmd_lane.sv
`default_nettype none
module rdmd_lane
  import rdmd_pkg::*;
#(
  parameter int unsigned SPEED_BITS = 12
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  lane_ctrl_t                   ctrl_i,
  input  wire logic signed [SPEED_BITS-1:0] target_i,
  input  wire logic [STEP_W-1:0]       step_i,
  output logic signed [SPEED_BITS-1:0] speed_o
);

  localparam int unsigned RW = SPEED_BITS + 2;

  logic signed [SPEED_BITS-1:0] speed_q, speed_d;
  logic signed [SPEED_BITS-1:0] out_q;
  logic signed [RW-1:0]         cur, goal, step, up, dn, ramped;

  always_comb begin
    cur  = RW'(speed_q);
    goal = RW'(target_i);
    step = signed'(RW'(step_i));
    up   = cur + step;
    dn   = cur - step;
    if (cur < goal) begin
      ramped = (up < goal) ? up : goal;
    end else if (cur > goal) begin
      ramped = (dn > goal) ? dn : goal;
    end else begin
      ramped = cur;
    end
  end

  always_comb begin
    unique case (ctrl_i.op)
      LOP_HOLD: speed_d = speed_q;
      LOP_SET:  speed_d = target_i;
      LOP_RAMP: speed_d = ramped[SPEED_BITS-1:0];
      LOP_ZERO: speed_d = '0;
      default:  speed_d = speed_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
    end else if (en_i) begin
      speed_q <= speed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctrl_i.emit) begin
      out_q <= speed_d;
    end
  end

  assign speed_o = out_q;

endmodule
`default_nettype wire

FILE: rtl/rdmd_split.sv
`default_nettype none
module rdmd_split
  import rdmd_pkg::*;
#(
  parameter int unsigned SPEED_BITS = 12,
  parameter int unsigned DUTY_BITS  = 10
) (
  input  wire logic signed [SPEED_BITS-1:0] speed_i,
  input  wire logic [PWM_W-1:0]             pwm_limit_i,
  output dir_e                              dir_o,
  output logic [DUTY_BITS-1:0]              duty_o
);

  localparam int unsigned MW = (SPEED_BITS > DUTY_BITS) ? SPEED_BITS : DUTY_BITS;
  localparam int unsigned CW = ((MW > PWM_W) ? MW : PWM_W) + 2;
  localparam logic signed [CW-1:0] DMAX = CW'((64'd1 << DUTY_BITS) - 64'd1);

  logic signed [CW-1:0] spd, pwm, lim, clamped, mag;

  always_comb begin
    spd = CW'(speed_i);
    pwm = signed'(CW'(pwm_limit_i));
    lim = (pwm > DMAX) ? DMAX : pwm;
    if (spd > lim) begin
      clamped = lim;
    end else if (spd < -lim) begin
      clamped = -lim;
    end else begin
      clamped = spd;
    end
    if (clamped > 0) begin
      dir_o = DIR_FWD;
      mag   = clamped;
    end else if (clamped < 0) begin
      dir_o = DIR_REV;
      mag   = -clamped;
    end else begin
      dir_o = DIR_OFF;
      mag   = '0;
    end
    duty_o = mag[DUTY_BITS-1:0];
  end

endmodule
`default_nettype wire

FILE: rtl/rdmd_merge.sv
`default_nettype none
module rdmd_merge
  import rdmd_pkg::*;
#(
  parameter int unsigned DUTY_BITS = 10,
  parameter int unsigned OUT_W     = 32
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       valid_i,
  output logic                      ready_o,
  input  dir_e                      left_dir_i,
  input  wire logic [DUTY_BITS-1:0] left_duty_i,
  input  dir_e                      right_dir_i,
  input  wire logic [DUTY_BITS-1:0] right_duty_i,
  input  flags_t                    flags_i,
  output logic                      m_axis_tvalid,
  input  wire                       m_axis_tready,
  output logic [OUT_W-1:0]          m_axis_tdata
);

  localparam int unsigned PACK_W = 2 * DUTY_BITS + 6;

  logic             valid_q;
  logic [OUT_W-1:0] data_q;
  logic [PACK_W-1:0] packed_beat;

  assign packed_beat = {flags_i.obstacle_event, flags_i.safety_active,
                        right_duty_i, right_dir_i, left_duty_i, left_dir_i};

  assign ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= OUT_W'(packed_beat);
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule
`default_nettype wire

FILE: rtl/ramped_differential_motor_drive.sv
// Each accepted beat is registered in the lanes, split, then registered again in the merge.
// Throughput: one beat per cycle unless m_axis stalls; lanes update held speed per beat.
// Begin commands and ramped updates with drive mode off produce no result beat.
// Reset (rst_ni low, asynchronous): held speeds zero, safety latch and command clear,
// registers at ramp_step 5, pwm_limit 1023, obstacle_limit 80; no beat pending.
`default_nettype none
module ramped_differential_motor_drive
  import rdmd_pkg::*;
#(
  parameter int unsigned SPEED_BITS = 12,
  parameter int unsigned DUTY_BITS  = 10
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // left_target, right_target, distance, mode_drive
  input  wire logic [((2*SPEED_BITS+DIST_W+1+7)/8)*8-1:0] s_axis_tdata,
  // cmd
  input  wire logic [CMD_W-1:0]         s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // left_dir, left_duty, right_dir, right_duty, safety_active, obstacle_event
  output logic [((2*DUTY_BITS+6+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned OUT_W = ((2*DUTY_BITS+6+7)/8)*8;

  logic [STEP_W-1:0] ramp_step_q;
  logic [PWM_W-1:0]  pwm_limit_q;
  logic [DIST_W-1:0] obstacle_limit_q;

  logic safety_q, safety_d;
  logic active_q, active_d;
  logic p1_valid_q;
  flags_t flags_q, flags_d;
  logic p1_ready, accept;

  cmd_e                         cmd;
  logic signed [SPEED_BITS-1:0] left_target, right_target;
  logic [DIST_W-1:0]            distance;
  logic                         mode_drive, obstacle;
  lane_ctrl_t                   ctrl;

  logic signed [SPEED_BITS-1:0] left_speed, right_speed;
  dir_e                         left_dir, right_dir;
  logic [DUTY_BITS-1:0]         left_duty, right_duty;

  assign cmd          = cmd_e'(s_axis_tuser);
  assign left_target  = s_axis_tdata[SPEED_BITS-1:0];
  assign right_target = s_axis_tdata[2*SPEED_BITS-1:SPEED_BITS];
  assign distance     = s_axis_tdata[2*SPEED_BITS+DIST_W-1:2*SPEED_BITS];
  assign mode_drive   = s_axis_tdata[2*SPEED_BITS+DIST_W];
  assign obstacle     = (distance != '0) && (distance <= obstacle_limit_q);

  assign s_axis_tready = !p1_valid_q || p1_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q      <= RAMP_STEP_RST;
      pwm_limit_q      <= PWM_LIMIT_RST;
      obstacle_limit_q <= OBSTACLE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RAMP_STEP:      ramp_step_q      <= cfg_data_i[STEP_W-1:0];
        REG_PWM_LIMIT:      pwm_limit_q      <= cfg_data_i[PWM_W-1:0];
        REG_OBSTACLE_LIMIT: obstacle_limit_q <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    safety_d  = safety_q;
    active_d  = active_q;
    flags_d   = '0;
    ctrl.op   = LOP_HOLD;
    ctrl.emit = 1'b0;
    unique case (cmd)
      CMD_BEGIN: begin
        active_d = 1'b1;
        safety_d = 1'b0;
      end
      CMD_END: begin
        active_d  = 1'b0;
        safety_d  = 1'b0;
        ctrl.op   = LOP_ZERO;
        ctrl.emit = 1'b1;
      end
      CMD_SET, CMD_RAMP: begin
        if (cmd == CMD_SET || mode_drive) begin
          ctrl.emit = 1'b1;
          if (active_q && obstacle) begin
            safety_d               = 1'b1;
            ctrl.op                = LOP_ZERO;
            flags_d.obstacle_event = !safety_q;
          end else begin
            if (active_q) begin
              safety_d = 1'b0;
            end
            ctrl.op = (cmd == CMD_RAMP) ? LOP_RAMP : LOP_SET;
          end
        end
      end
      default: ;
    endcase
    flags_d.safety_active = safety_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safety_q   <= 1'b0;
      active_q   <= 1'b0;
      p1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        safety_q <= safety_d;
        active_q <= active_d;
      end
      if (accept && ctrl.emit) begin
        p1_valid_q <= 1'b1;
      end else if (p1_ready) begin
        p1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && ctrl.emit) begin
      flags_q <= flags_d;
    end
  end

  rdmd_lane #(.SPEED_BITS(SPEED_BITS)) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (accept),
    .ctrl_i   (ctrl),
    .target_i (left_target),
    .step_i   (ramp_step_q),
    .speed_o  (left_speed)
  );

  rdmd_lane #(.SPEED_BITS(SPEED_BITS)) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (accept),
    .ctrl_i   (ctrl),
    .target_i (right_target),
    .step_i   (ramp_step_q),
    .speed_o  (right_speed)
  );

  rdmd_split #(.SPEED_BITS(SPEED_BITS), .DUTY_BITS(DUTY_BITS)) u_split_left (
    .speed_i     (left_speed),
    .pwm_limit_i (pwm_limit_q),
    .dir_o       (left_dir),
    .duty_o      (left_duty)
  );

  rdmd_split #(.SPEED_BITS(SPEED_BITS), .DUTY_BITS(DUTY_BITS)) u_split_right (
    .speed_i     (right_speed),
    .pwm_limit_i (pwm_limit_q),
    .dir_o       (right_dir),
    .duty_o      (right_duty)
  );

  rdmd_merge #(.DUTY_BITS(DUTY_BITS), .OUT_W(OUT_W)) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (p1_valid_q),
    .ready_o       (p1_ready),
    .left_dir_i    (left_dir),
    .left_duty_i   (left_duty),
    .right_dir_i   (right_dir),
    .right_duty_i  (right_duty),
    .flags_i       (flags_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

FILE: verif/tb_ramped_differential_motor_drive.sv
`default_nettype none
module tb_ramped_differential_motor_drive;
  import rdmd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SPEED_W = 12;
  localparam int unsigned DUTY_W  = 10;
  localparam int unsigned IN_W    = ((2*SPEED_W+DIST_W+1+7)/8)*8;
  localparam int unsigned OUT_W   = ((2*DUTY_W+6+7)/8)*8;
  localparam int          SPD_MAX = (1 << (SPEED_W-1)) - 1;
  localparam int          SPD_MIN = -(1 << (SPEED_W-1));
  localparam int          DUTY_MAX = (1 << DUTY_W) - 1;
  localparam int          SETTLE_CYCLES = 6;

  typedef struct {
    cmd_e                      cmd;
    logic signed [SPEED_W-1:0] left_tgt;
    logic signed [SPEED_W-1:0] right_tgt;
    logic [DIST_W-1:0]         obst_dist;
    logic                      drive;
  } drive_cmd_t;

  typedef struct {
    dir_e              left_dir;
    logic [DUTY_W-1:0] left_duty;
    dir_e              right_dir;
    logic [DUTY_W-1:0] right_duty;
    logic              safety;
    logic              obstacle;
  } bridge_out_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  reg_idx_e              cfg_idx_i = REG_RAMP_STEP;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;

  ramped_differential_motor_drive dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  drive_cmd_t  cmd_q[$];
  bridge_out_t bridge_q[$];
  drive_cmd_t  bus_cmd;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int n_errors     = 0;
  int n_sent       = 0;
  int n_checked    = 0;
  int n_stops      = 0;
  int n_settings   = 0;

  int   ramp_step_cfg = RAMP_STEP_RST;
  int   pwm_limit_cfg = PWM_LIMIT_RST;
  int   obst_limit_cfg = OBSTACLE_LIMIT_RST;
  int   held_left  = 0;
  int   held_right = 0;
  logic stop_latch = 1'b0;
  logic run_active = 1'b0;

  function automatic int ramp_toward(int cur, int goal, int step);
    if (cur < goal) return (cur + step < goal) ? cur + step : goal;
    if (cur > goal) return (cur - step > goal) ? cur - step : goal;
    return cur;
  endfunction

  function automatic void split_speed(input int spd, output dir_e dir,
                                      output logic [DUTY_W-1:0] duty);
    int lim;
    lim = (pwm_limit_cfg > DUTY_MAX) ? DUTY_MAX : pwm_limit_cfg;
    if (spd > lim) spd = lim;
    if (spd < -lim) spd = -lim;
    if (spd > 0) begin
      dir = DIR_FWD;
      duty = DUTY_W'(spd);
    end else if (spd < 0) begin
      dir = DIR_REV;
      duty = DUTY_W'(-spd);
    end else begin
      dir = DIR_OFF;
      duty = '0;
    end
  endfunction

  function automatic bridge_out_t bridge_state(logic fresh);
    bridge_out_t r;
    split_speed(held_left, r.left_dir, r.left_duty);
    split_speed(held_right, r.right_dir, r.right_duty);
    r.safety = stop_latch;
    r.obstacle = fresh;
    return r;
  endfunction

  // Advance the drive state by one command; push a bridge beat when one is due.
  function automatic void predict_drive(drive_cmd_t c);
    logic fresh;
    if (c.cmd == CMD_BEGIN) begin
      run_active = 1'b1;
      stop_latch = 1'b0;
      return;
    end
    if (c.cmd == CMD_END) begin
      run_active = 1'b0;
      stop_latch = 1'b0;
      held_left = 0;
      held_right = 0;
      bridge_q.push_back(bridge_state(1'b0));
      return;
    end
    if (c.cmd == CMD_RAMP && !c.drive) return;
    if (run_active) begin
      if (c.obst_dist != 0 && int'(c.obst_dist) <= obst_limit_cfg) begin
        fresh = !stop_latch;
        stop_latch = 1'b1;
        held_left = 0;
        held_right = 0;
        if (fresh) n_stops++;
        bridge_q.push_back(bridge_state(fresh));
        return;
      end
      stop_latch = 1'b0;
    end
    if (c.cmd == CMD_RAMP) begin
      held_left = ramp_toward(held_left, int'(c.left_tgt), ramp_step_cfg);
      held_right = ramp_toward(held_right, int'(c.right_tgt), ramp_step_cfg);
    end else begin
      held_left = int'(c.left_tgt);
      held_right = int'(c.right_tgt);
    end
    bridge_q.push_back(bridge_state(1'b0));
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_drive(bus_cmd);
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_q.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          bus_cmd = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= IN_W'({bus_cmd.drive, bus_cmd.obst_dist,
                                 bus_cmd.right_tgt, bus_cmd.left_tgt});
          s_axis_tuser <= bus_cmd.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, got_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    bridge_out_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (bridge_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $realtime, m_axis_tdata);
        n_errors++;
      end else begin
        e = bridge_q.pop_front();
        n_checked++;
        check_field("left_dir", int'(e.left_dir), int'(m_axis_tdata[1:0]));
        check_field("left_duty", int'(e.left_duty), int'(m_axis_tdata[11:2]));
        check_field("right_dir", int'(e.right_dir), int'(m_axis_tdata[13:12]));
        check_field("right_duty", int'(e.right_duty), int'(m_axis_tdata[23:14]));
        check_field("safety_active", int'(e.safety), int'(m_axis_tdata[24]));
        check_field("obstacle_event", int'(e.obstacle), int'(m_axis_tdata[25]));
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  function automatic drive_cmd_t mk_cmd(cmd_e cmd, int lt, int rt, int dist_v, bit drive);
    drive_cmd_t c;
    c.cmd = cmd;
    c.left_tgt = SPEED_W'(lt);
    c.right_tgt = SPEED_W'(rt);
    c.obst_dist = DIST_W'(dist_v);
    c.drive = drive;
    return c;
  endfunction

  function automatic int pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return SPD_MAX;
    if (r < 8) return SPD_MIN;
    if (r < 10) return 0;
    return int'($signed(SPEED_W'($urandom)));
  endfunction

  function automatic drive_cmd_t rand_cmd();
    drive_cmd_t c;
    int r;
    int d;
    r = $urandom_range(0, 99);
    if (r < 6) c.cmd = CMD_BEGIN;
    else if (r < 10) c.cmd = CMD_END;
    else if (r < 35) c.cmd = CMD_SET;
    else c.cmd = CMD_RAMP;
    c.left_tgt = SPEED_W'(pick_target());
    c.right_tgt = SPEED_W'(pick_target());
    c.drive = ($urandom_range(0, 99) < 85);
    r = $urandom_range(0, 99);
    if (r < 30) begin
      d = 0;
    end else if (r < 60) begin
      d = obst_limit_cfg + $urandom_range(0, 4) - 2;
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
    end else begin
      d = $urandom_range(0, 65535);
    end
    c.obst_dist = DIST_W'(d);
    return c;
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || s_axis_tvalid || bridge_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(int step, int lim, int obst);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_RAMP_STEP;
    cfg_data_i <= CFG_DATA_W'(step);
    @(posedge clk_i);
    cfg_idx_i <= REG_PWM_LIMIT;
    cfg_data_i <= CFG_DATA_W'(lim);
    @(posedge clk_i);
    cfg_idx_i <= REG_OBSTACLE_LIMIT;
    cfg_data_i <= CFG_DATA_W'(obst);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ramp_step_cfg = step;
    pwm_limit_cfg = lim;
    obst_limit_cfg = obst;
    n_settings++;
    @(posedge clk_i);
  endtask

  task automatic run_random(int step, int lim, int obst, int count);
    wait_idle();
    program_regs(step, lim, obst);
    repeat (count) cmd_q.push_back(rand_cmd());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    snd_idle_pct = 25;
    rcv_idle_pct = 68;
    program_regs(RAMP_STEP_RST, PWM_LIMIT_RST, OBSTACLE_LIMIT_RST);

    cmd_q.push_back(mk_cmd(CMD_SET, SPD_MAX, SPD_MIN, 10, 1'b0));
    cmd_q.push_back(mk_cmd(CMD_RAMP, 0, 0, 0, 1'b0));
    cmd_q.push_back(mk_cmd(CMD_RAMP, 0, 0, 0, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_BEGIN, 0, 0, 0, 1'b0));
    cmd_q.push_back(mk_cmd(CMD_SET, SPD_MIN, SPD_MAX, 0, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_SET, 300, -300, 80, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_SET, 300, -300, 1, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_RAMP, 100, -100, 81, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_RAMP, -3, 3, 65535, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_RAMP, -3, 3, 65535, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_RAMP, 500, 500, 5, 1'b0));
    cmd_q.push_back(mk_cmd(CMD_END, 7, 7, 0, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_SET, 1, -1, 5, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_BEGIN, 0, 0, 0, 1'b0));
    cmd_q.push_back(mk_cmd(CMD_BEGIN, 0, 0, 0, 1'b0));
    cmd_q.push_back(mk_cmd(CMD_SET, 0, 0, 0, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_RAMP, SPD_MAX, SPD_MIN, 0, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_SET, 1024, -1024, 0, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_SET, 0, 0, 40, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_END, 0, 0, 40, 1'b1));
    cmd_q.push_back(mk_cmd(CMD_SET, -1, 1, 0, 1'b0));

    run_random(RAMP_STEP_RST, PWM_LIMIT_RST, OBSTACLE_LIMIT_RST, 300);
    run_random(255, 1023, 65535, 280);
    wait_idle();
    snd_idle_pct = 68;
    rcv_idle_pct = 25;
    run_random(0, 0, 0, 200);
    run_random(1, 1, 1, 280);
    wait_idle();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random($urandom_range(0, 255), $urandom_range(0, 1023), $urandom_range(0, 65535), 280);
    run_random(37, 511, 200, 300);
    wait_idle();

    $display("Covered %0d command beats and %0d bridge beats over %0d register settings,",
             n_sent, n_checked, n_settings);
    $display("with %0d fresh obstacle stops under three idle patterns.", n_stops);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
